[hw/rtl/radius_outlier_filter_2d_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the radius outlier filter
// Clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef RADIUS_OUTLIER_FILTER_2D_MACROS_SVH
`define RADIUS_OUTLIER_FILTER_2D_MACROS_SVH

// same-cycle implication
`define ROF_ASSERT_IMPLY(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define ROF_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("next-cycle implication violated");

`endif

[hw/rtl/rof_pkg.sv]
// ----------------------------------------------------------------------------
// rof_pkg
// Types and constants shared by the radius outlier filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rof_pkg;

	localparam int COORD_W  = 20;
	localparam int SLOT_W   = 12;
	localparam int CNT_W    = 8;
	localparam int RAD_W    = 42;
	localparam int OP_W     = 2;
	localparam int FAULT_W  = 2;
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 42;

	localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
	localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

	localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_FULL = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_SLOT = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MIN_NEIGHBORS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REMOVE_ZERO   = 2'd2;

	localparam logic [CNT_W-1:0] MIN_NEIGHBORS_RST = 8'd5;
	localparam logic [RAD_W-1:0] RADIUS_SQ_RST     = 42'd40000;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      point_finite;
		logic [SLOT_W-1:0]         query_slot;
	} in_item_t;

	typedef struct packed {
		logic                      accepted;
		logic [SLOT_W-1:0]         slot_index;
		logic                      keep;
		logic [CNT_W-1:0]          neighbor_count;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic [FAULT_W-1:0]        fault;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic accept;
		logic ref_read;
		logic scan_issue;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic classify_ok;
		logic scan_last;
		logic busy;
		logic out_free;
	} ctrl_status_t;

endpackage

`default_nettype wire

[hw/rtl/rof_ram.sv]
// ----------------------------------------------------------------------------
// rof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rof_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/rof_ctrl.sv]
// ----------------------------------------------------------------------------
// rof_ctrl
// Sequencer: accepts a transaction, runs the neighbor scan, emits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rof_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  rof_pkg::ctrl_status_t status,
	output rof_pkg::ctrl_cmd_t    cmd
);

	import rof_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_REF   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = status.classify_ok ? ST_REF : ST_EMIT;
				end
			end
			ST_REF, ST_SCAN: begin
				state_d = status.scan_last ? ST_DRAIN : ST_SCAN;
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready     = (state_q == ST_IDLE);
	assign cmd.accept     = (state_q == ST_IDLE) && item_valid;
	assign cmd.ref_read   = (state_q == ST_REF);
	assign cmd.scan_issue = (state_q == ST_REF) || (state_q == ST_SCAN);
	assign cmd.emit       = (state_q == ST_EMIT) && status.out_free;

endmodule

`default_nettype wire

[hw/rtl/rof_dp.sv]
// ----------------------------------------------------------------------------
// rof_dp
// Datapath: point store, config registers, distance pipeline, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rof_dp #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rof_pkg::in_item_t                   item,
	input  logic                                write_enable,
	input  logic [rof_pkg::REG_IDX_W-1:0]       register_index,
	input  logic [rof_pkg::REG_DATA_W-1:0]      write_data,
	input  rof_pkg::ctrl_cmd_t                  cmd,
	output rof_pkg::ctrl_status_t               status,
	output logic                                result_valid,
	input  logic                                result_ready,
	output rof_pkg::out_item_t                  result
);

	import rof_pkg::*;

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int TW    = $clog2(MAX_POINTS + 1);
	localparam int EW    = (TW > SLOT_W) ? TW : SLOT_W;
	localparam int ABS_W = COORD_W + 1;
	localparam int SQ_W  = 2 * ABS_W;
	localparam int SUM_W = SQ_W + 1;
	localparam logic [TW-1:0] MAX_TOTAL = TW'(MAX_POINTS);

	// configuration
	logic [CNT_W-1:0] min_q;
	logic [RAD_W-1:0] radius_q;
	logic             rz_q;

	// control state
	logic [TW-1:0]    total_q;
	logic [AW-1:0]    scan_q;
	logic             rd_vld_q;
	logic             vld_s1;
	logic             vld_s2;
	logic             vld_s3;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	// payload
	logic [OP_W-1:0]    op_q;
	logic [SLOT_W-1:0]  qslot_q;
	logic               acc_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [FAULT_W-1:0] fault_q;
	point_t             ref_q;
	logic [ABS_W-1:0]   ax_s1;
	logic [ABS_W-1:0]   ay_s1;
	logic [SQ_W-1:0]    sqx_s2;
	logic [SQ_W-1:0]    sqy_s2;
	logic               hit_s3;
	out_item_t          out_q;

	logic [EW-1:0]          total_e;
	logic [EW-1:0]          query_e;
	logic [AW-1:0]          ram_raddr;
	logic [$bits(point_t)-1:0] ram_rdata;
	point_t                 rd_pt;
	point_t                 wr_pt;
	logic                   all_zero;
	logic                   load_ok;
	logic                   load_full;
	logic                   store_we;
	logic [TW-1:0]          last_idx;
	logic signed [ABS_W-1:0] dx;
	logic signed [ABS_W-1:0] dy;
	logic [SUM_W-1:0]       dist_sq;
	out_item_t              res_d;

	assign total_e  = EW'(total_q);
	assign query_e  = EW'(item.query_slot);
	assign all_zero = (item.point_x == '0) && (item.point_y == '0) && (item.point_z == '0);
	assign load_ok  = item.point_finite && !(rz_q && all_zero) && (total_q < MAX_TOTAL);
	assign load_full = item.point_finite && !(rz_q && all_zero) && (total_q >= MAX_TOTAL);
	assign store_we = cmd.accept && (item.operation == OP_LOAD) && load_ok;
	assign last_idx = total_q - TW'(1);

	assign wr_pt.x = item.point_x;
	assign wr_pt.y = item.point_y;
	assign wr_pt.z = item.point_z;

	assign ram_raddr = cmd.accept ? query_e[AW-1:0] : scan_q;

	rof_ram #(
		.WIDTH($bits(point_t)),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(total_q[AW-1:0]),
		.wdata(wr_pt),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_pt = point_t'(ram_rdata);

	assign status.classify_ok = (item.operation == OP_CLASSIFY) && (query_e < total_e);
	assign status.scan_last   = (TW'(scan_q) == last_idx);
	assign status.busy        = rd_vld_q || vld_s1 || vld_s2 || vld_s3;
	assign status.out_free    = !out_valid_q || result_ready;

	assign dx   = {rd_pt.x[COORD_W-1], rd_pt.x} - {ref_q.x[COORD_W-1], ref_q.x};
	assign dy   = {rd_pt.y[COORD_W-1], rd_pt.y} - {ref_q.y[COORD_W-1], ref_q.y};
	assign dist_sq = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= MIN_NEIGHBORS_RST;
			radius_q    <= RADIUS_SQ_RST;
			rz_q        <= 1'b0;
			total_q     <= '0;
			scan_q      <= '0;
			rd_vld_q    <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (write_enable) begin
				case (register_index)
					REG_MIN_NEIGHBORS: min_q    <= write_data[CNT_W-1:0];
					REG_RADIUS_SQ:     radius_q <= write_data[RAD_W-1:0];
					REG_REMOVE_ZERO:   rz_q     <= write_data[0];
					default: ;
				endcase
			end
			if (store_we) begin
				total_q <= total_q + TW'(1);
			end else if (cmd.accept && (item.operation == OP_CLEAR)) begin
				total_q <= '0;
			end
			if (cmd.accept) begin
				scan_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.scan_issue) begin
					scan_q <= scan_q + AW'(1);
				end
				if (vld_s3 && hit_s3 && (count_q < min_q)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			rd_vld_q <= cmd.scan_issue;
			vld_s1   <= rd_vld_q;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= item.operation;
			qslot_q <= item.query_slot;
			acc_q   <= 1'b0;
			slot_q  <= '0;
			fault_q <= FAULT_NONE;
			case (item.operation)
				OP_LOAD: begin
					if (load_ok) begin
						acc_q  <= 1'b1;
						slot_q <= total_e[SLOT_W-1:0];
					end else if (load_full) begin
						fault_q <= FAULT_FULL;
					end
				end
				OP_CLASSIFY: begin
					if (!status.classify_ok) begin
						fault_q <= FAULT_SLOT;
					end
				end
				default: ;
			endcase
		end
		if (cmd.ref_read) begin
			ref_q <= rd_pt;
		end
		ax_s1  <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
		ay_s1  <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
		sqx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
		sqy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
		hit_s3 <= (dist_sq <= SUM_W'(radius_q));
		if (cmd.emit) begin
			out_q <= res_d;
		end
	end

	always_comb begin
		res_d = '0;
		case (op_q)
			OP_LOAD: begin
				res_d.accepted   = acc_q;
				res_d.slot_index = slot_q;
				res_d.fault      = fault_q;
			end
			OP_CLASSIFY: begin
				res_d.slot_index = qslot_q;
				res_d.fault      = fault_q;
				if (fault_q == FAULT_NONE) begin
					res_d.keep           = (count_q >= min_q);
					res_d.neighbor_count = count_q;
					res_d.out_x          = ref_q.x;
					res_d.out_y          = ref_q.y;
					res_d.out_z          = ref_q.z;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

[hw/rtl/radius_outlier_filter_2d.sv]
// ----------------------------------------------------------------------------
// radius_outlier_filter_2d
// Radius outlier filter over a store of XY(Z) points, counting neighbors
// inside a configurable radius.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | kind
//  ----------+------------------------------------------+---------------
//  item      | item_valid, item_ready, item             | valid/ready in
//  result    | result_valid, result_ready, result       | valid/ready out
//  config    | write_enable, register_index, write_data | write-only
//
//  Load, clear, unused operations and a classify of an unstored slot go
//  from accept straight to emit.
//  Classify steps: accept, one store read per cycle through the single RAM
//  read port, the distance pipeline drain, and emit.
//  Reset clears the point count; the store needs no clearing pass.
//  A held result stalls only the final emit; the next transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radius_outlier_filter_2d_macros.svh"

module radius_outlier_filter_2d #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  rof_pkg::in_item_t              item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output rof_pkg::out_item_t             result,
	input  logic                           write_enable,
	input  logic [rof_pkg::REG_IDX_W-1:0]  register_index,
	input  logic [rof_pkg::REG_DATA_W-1:0] write_data
);

	import rof_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	rof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rof_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.write_enable  (write_enable),
		.register_index(register_index),
		.write_data    (write_data),
		.cmd           (cmd),
		.status        (status),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result)
	);

	`ROF_ASSERT_IMPLY(a_no_accept_in_scan, clk, arst_n, cmd.scan_issue, !item_ready)
	`ROF_ASSERT_IMPLY(a_emit_when_free, clk, arst_n, cmd.emit, status.out_free)
	`ROF_ASSERT_NEXT(a_emit_shows, clk, arst_n, cmd.emit, result_valid)

endmodule

`default_nettype wire
